### hw/rtl/ohlcv_pkg.sv
// Shared widths, type codes, register indexes and structs for the OHLCV bar aggregator.
// No dependencies; every other file of the block refers to this package by scoped names.
package ohlcv_pkg;

    localparam int TIME_W   = 48;
    localparam int PRICE_W  = 31;
    localparam int TVOL_W   = 32;
    localparam int TYPE_W   = 8;
    localparam int VOL_W    = 40;
    localparam int AMT_W    = 63;
    localparam int IVL_W    = 11;
    localparam int LIMIT_W  = 27;
    localparam int CFG_IDX_W = 2;

    localparam logic [TYPE_W-1:0] TYPE_AUCTION = 8'd49;
    localparam logic [TYPE_W-1:0] TYPE_REGULAR = 8'd50;

    localparam int SEC_PER_MIN = 60;
    localparam int MS_PER_SEC  = 1000;
    localparam int MS_PER_MIN  = SEC_PER_MIN * MS_PER_SEC;

    localparam logic [LIMIT_W-1:0] MS_PER_MIN_L = LIMIT_W'(MS_PER_MIN);
    // one minute: the timeout after reset
    localparam logic [LIMIT_W-1:0] RESET_LIMIT  = LIMIT_W'(MS_PER_MIN);

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HISTORY  = 2'd1;

    localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};
    localparam logic [AMT_W-1:0] AMT_MAX = {AMT_W{1'b1}};

    typedef struct packed {
        logic [TIME_W-1:0]  time_ms;
        logic [PRICE_W-1:0] price;
        logic [TVOL_W-1:0]  volume;
        logic               is_auction;
        logic               is_regular;
        logic [AMT_W-1:0]   product;
    } tick_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] limit_ms;
        logic               history_ready;
    } cfg_t;

endpackage

### hw/rtl/ohlcv_cfg.sv
// Configuration registers of the OHLCV bar aggregator: bar timeout and history gate.
// Depends on ohlcv_pkg.
module ohlcv_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ohlcv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ohlcv_pkg::IVL_W-1:0]       cfg_data,
    output ohlcv_pkg::cfg_t                   cfg
);

    logic [ohlcv_pkg::LIMIT_W-1:0] limit_reg;
    logic [ohlcv_pkg::LIMIT_W-1:0] limit_next;
    logic                          hist_reg;
    logic                          hist_next;

    assign cfg_ready = 1'b1;

    // hold the timeout in ms, so the bar path never multiplies
    always_comb
    begin
        limit_next = limit_reg;
        hist_next  = hist_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ohlcv_pkg::CFG_IDX_INTERVAL:
                begin
                    limit_next = ohlcv_pkg::LIMIT_W'(cfg_data) * ohlcv_pkg::MS_PER_MIN_L;
                end
                ohlcv_pkg::CFG_IDX_HISTORY:
                begin
                    hist_next = cfg_data[0];
                end
                default:
                begin
                    limit_next = limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= ohlcv_pkg::RESET_LIMIT;
            hist_reg  <= 1'b0;
        end
        else
        begin
            limit_reg <= limit_next;
            hist_reg  <= hist_next;
        end
    end

    assign cfg.limit_ms      = limit_reg;
    assign cfg.history_ready = hist_reg;

endmodule

### hw/rtl/ohlcv_mul.sv
// Input stage of the OHLCV bar aggregator: registers the tick, decodes its type, forms turnover.
// Depends on ohlcv_pkg.
module ohlcv_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ohlcv_pkg::TIME_W-1:0]    tick_time_ms,
    input  logic [ohlcv_pkg::PRICE_W-1:0]   price,
    input  logic [ohlcv_pkg::TVOL_W-1:0]    tick_volume,
    input  logic [ohlcv_pkg::TYPE_W-1:0]    trade_type,
    input  logic                            b_ready,
    output logic                            a_valid,
    output ohlcv_pkg::tick_t                a_tick
);

    logic             a_valid_reg;
    logic             a_valid_next;
    ohlcv_pkg::tick_t a_tick_reg;
    ohlcv_pkg::tick_t a_tick_next;
    logic             a_load;

    assign in_stall     = a_valid_reg & ~b_ready;
    assign a_load       = in_valid & ~in_stall;
    assign a_valid_next = a_load | (a_valid_reg & ~b_ready);

    always_comb
    begin
        a_tick_next.time_ms    = tick_time_ms;
        a_tick_next.price      = price;
        a_tick_next.volume     = tick_volume;
        a_tick_next.is_auction = (trade_type == ohlcv_pkg::TYPE_AUCTION);
        a_tick_next.is_regular = (trade_type == ohlcv_pkg::TYPE_REGULAR);
        // 32 x 31 product always fits the 63-bit turnover
        a_tick_next.product    = ohlcv_pkg::AMT_W'(tick_volume) * ohlcv_pkg::AMT_W'(price);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_tick_reg <= a_tick_next;
        end
    end

    assign a_valid = a_valid_reg;
    assign a_tick  = a_tick_reg;

endmodule

### hw/rtl/ohlcv_bar.sv
// Bar and session state of the OHLCV bar aggregator, with the result register.
// Depends on ohlcv_pkg.
module ohlcv_bar (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            a_valid,
    input  ohlcv_pkg::tick_t                a_tick,
    input  ohlcv_pkg::cfg_t                 cfg,
    output logic                            b_ready,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            accepted,
    output logic                            bar_closed,
    output logic [ohlcv_pkg::TIME_W-1:0]    closed_start_ms,
    output logic [ohlcv_pkg::PRICE_W-1:0]   closed_open,
    output logic [ohlcv_pkg::PRICE_W-1:0]   closed_high,
    output logic [ohlcv_pkg::PRICE_W-1:0]   closed_low,
    output logic [ohlcv_pkg::PRICE_W-1:0]   closed_last,
    output logic [ohlcv_pkg::VOL_W-1:0]     closed_volume,
    output logic [ohlcv_pkg::AMT_W-1:0]     closed_amount,
    output logic                            closed_auction,
    output logic [ohlcv_pkg::PRICE_W-1:0]   session_high,
    output logic [ohlcv_pkg::PRICE_W-1:0]   session_low
);

    // bar and session state
    logic                           open_reg,    open_next;
    logic [ohlcv_pkg::TIME_W-1:0]   start_reg,   start_next;
    logic [ohlcv_pkg::PRICE_W-1:0]  first_reg,   first_next;
    logic [ohlcv_pkg::PRICE_W-1:0]  top_reg,     top_next;
    logic [ohlcv_pkg::PRICE_W-1:0]  bottom_reg,  bottom_next;
    logic [ohlcv_pkg::PRICE_W-1:0]  latest_reg,  latest_next;
    logic [ohlcv_pkg::VOL_W-1:0]    vol_reg,     vol_next;
    logic [ohlcv_pkg::AMT_W-1:0]    turn_reg,    turn_next;
    logic                           auct_reg,    auct_next;
    logic [ohlcv_pkg::PRICE_W-1:0]  dhigh_reg,   dhigh_next;
    logic [ohlcv_pkg::PRICE_W-1:0]  dlow_reg,    dlow_next;

    // result register
    logic                           ovalid_reg,  ovalid_next;
    logic                           acc_reg;
    logic                           closed_reg;
    logic [ohlcv_pkg::TIME_W-1:0]   c_start_reg;
    logic [ohlcv_pkg::PRICE_W-1:0]  c_open_reg;
    logic [ohlcv_pkg::PRICE_W-1:0]  c_high_reg;
    logic [ohlcv_pkg::PRICE_W-1:0]  c_low_reg;
    logic [ohlcv_pkg::PRICE_W-1:0]  c_last_reg;
    logic [ohlcv_pkg::VOL_W-1:0]    c_vol_reg;
    logic [ohlcv_pkg::AMT_W-1:0]    c_amt_reg;
    logic                           c_auct_reg;
    logic [ohlcv_pkg::PRICE_W-1:0]  s_high_reg;
    logic [ohlcv_pkg::PRICE_W-1:0]  s_low_reg;

    logic                           fire;
    logic                           hist;
    logic [ohlcv_pkg::TIME_W-1:0]   elapsed;
    logic                           timeout;
    logic                           flip;
    logic                           do_close;
    logic                           do_open;
    logic                           do_update;
    logic [ohlcv_pkg::VOL_W:0]      vol_sum;
    logic [ohlcv_pkg::AMT_W:0]      turn_sum;

    assign b_ready     = ~(ovalid_reg & out_stall);
    assign fire        = a_valid & b_ready;
    assign ovalid_next = fire | (ovalid_reg & out_stall);
    assign hist        = cfg.history_ready;

    assign elapsed   = a_tick.time_ms - start_reg;
    assign timeout   = (a_tick.time_ms > start_reg) &&
                       (elapsed > ohlcv_pkg::TIME_W'(cfg.limit_ms));
    assign flip      = auct_reg ^ a_tick.is_auction;
    assign do_close  = hist & open_reg & (timeout | flip);
    assign do_open   = hist & (~open_reg | do_close);
    assign do_update = hist & open_reg & ~do_close;

    assign vol_sum  = {1'b0, vol_reg} + (ohlcv_pkg::VOL_W + 1)'(a_tick.volume);
    assign turn_sum = {1'b0, turn_reg} + {1'b0, a_tick.product};

    always_comb
    begin
        open_next   = open_reg;
        start_next  = start_reg;
        first_next  = first_reg;
        top_next    = top_reg;
        bottom_next = bottom_reg;
        latest_next = latest_reg;
        vol_next    = vol_reg;
        turn_next   = turn_reg;
        auct_next   = auct_reg;
        dhigh_next  = dhigh_reg;
        dlow_next   = dlow_reg;

        if (hist)
        begin
            // zero low means unset; a zero price clears it again
            if ((dlow_reg == '0) || (dlow_reg > a_tick.price))
            begin
                dlow_next = a_tick.price;
            end
            if (a_tick.price > dhigh_reg)
            begin
                dhigh_next = a_tick.price;
            end
        end

        if (do_open)
        begin
            open_next   = 1'b1;
            start_next  = a_tick.time_ms;
            first_next  = a_tick.price;
            top_next    = a_tick.price;
            bottom_next = a_tick.price;
            latest_next = a_tick.price;
            vol_next    = ohlcv_pkg::VOL_W'(a_tick.volume);
            auct_next   = a_tick.is_auction;
            turn_next   = a_tick.is_regular ? a_tick.product : '0;
        end
        else if (do_update)
        begin
            if (a_tick.price > top_reg)
            begin
                top_next = a_tick.price;
            end
            if (a_tick.price < bottom_reg)
            begin
                bottom_next = a_tick.price;
            end
            latest_next = a_tick.price;
            vol_next    = vol_sum[ohlcv_pkg::VOL_W] ? ohlcv_pkg::VOL_MAX
                                                    : vol_sum[ohlcv_pkg::VOL_W-1:0];
            if (a_tick.is_regular)
            begin
                turn_next = turn_sum[ohlcv_pkg::AMT_W] ? ohlcv_pkg::AMT_MAX
                                                       : turn_sum[ohlcv_pkg::AMT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            start_reg  <= '0;
            first_reg  <= '0;
            top_reg    <= '0;
            bottom_reg <= '0;
            latest_reg <= '0;
            vol_reg    <= '0;
            turn_reg   <= '0;
            auct_reg   <= 1'b0;
            dhigh_reg  <= '0;
            dlow_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            if (fire)
            begin
                open_reg   <= open_next;
                start_reg  <= start_next;
                first_reg  <= first_next;
                top_reg    <= top_next;
                bottom_reg <= bottom_next;
                latest_reg <= latest_next;
                vol_reg    <= vol_next;
                turn_reg   <= turn_next;
                auct_reg   <= auct_next;
                dhigh_reg  <= dhigh_next;
                dlow_reg   <= dlow_next;
            end
        end
    end

    // result payload: closed bar fields read as zero unless a bar closed
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            acc_reg     <= hist;
            closed_reg  <= do_close;
            c_start_reg <= do_close ? start_reg  : '0;
            c_open_reg  <= do_close ? first_reg  : '0;
            c_high_reg  <= do_close ? top_reg    : '0;
            c_low_reg   <= do_close ? bottom_reg : '0;
            c_last_reg  <= do_close ? latest_reg : '0;
            c_vol_reg   <= do_close ? vol_reg    : '0;
            c_amt_reg   <= do_close ? turn_reg   : '0;
            c_auct_reg  <= do_close & auct_reg;
            s_high_reg  <= dhigh_next;
            s_low_reg   <= dlow_next;
        end
    end

    assign out_valid       = ovalid_reg;
    assign accepted        = acc_reg;
    assign bar_closed      = closed_reg;
    assign closed_start_ms = c_start_reg;
    assign closed_open     = c_open_reg;
    assign closed_high     = c_high_reg;
    assign closed_low      = c_low_reg;
    assign closed_last     = c_last_reg;
    assign closed_volume   = c_vol_reg;
    assign closed_amount   = c_amt_reg;
    assign closed_auction  = c_auct_reg;
    assign session_high    = s_high_reg;
    assign session_low     = s_low_reg;

endmodule

### hw/rtl/tick_to_ohlcv_bar_aggregator_core.sv
// Top level of the tick to OHLCV bar aggregator.
// Depends on ohlcv_pkg, ohlcv_cfg, ohlcv_mul and ohlcv_bar.
//
// Usage:
//   Tick channel: in_valid / in_stall with tick_time_ms, price, tick_volume and
//   trade_type. An item is taken at a rising edge with in_valid high and in_stall low.
//   Result channel: out_valid / out_stall; one result item per tick item, in order.
//   Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects the
//   register (0: bar interval in minutes, 1: history ready), cfg_data holds the value.
//   Write config only while no items are in flight.
// Timing:
//   A tick taken at a rising edge sits in the input register; the bar stage registers
//   its result item from there once the result register is not held by out_stall.
//   One tick per cycle sustained while out_stall is low: the input stage forms the volume x price product,
//   the bar stage does one compare-and-accumulate on the bar state, and the two overlap.
// Reset:
//   rst_n clears all bar and session state, sets the interval to one minute and
//   history ready to 0; while history ready is 0 each tick still returns one
//   result item, marked not accepted, and changes nothing.
// Stall:
//   While out_stall is high the result register holds; the input stage keeps at
//   most one further tick, then raises in_stall until the result is taken.
module tick_to_ohlcv_bar_aggregator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // tick channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ohlcv_pkg::TIME_W-1:0]    tick_time_ms,
    input  logic [ohlcv_pkg::PRICE_W-1:0]   price,
    input  logic [ohlcv_pkg::TVOL_W-1:0]    tick_volume,
    input  logic [ohlcv_pkg::TYPE_W-1:0]    trade_type,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            accepted,
    output logic                            bar_closed,
    output logic [ohlcv_pkg::TIME_W-1:0]    closed_start_ms,
    output logic [ohlcv_pkg::PRICE_W-1:0]   closed_open,
    output logic [ohlcv_pkg::PRICE_W-1:0]   closed_high,
    output logic [ohlcv_pkg::PRICE_W-1:0]   closed_low,
    output logic [ohlcv_pkg::PRICE_W-1:0]   closed_last,
    output logic [ohlcv_pkg::VOL_W-1:0]     closed_volume,
    output logic [ohlcv_pkg::AMT_W-1:0]     closed_amount,
    output logic                            closed_auction,
    output logic [ohlcv_pkg::PRICE_W-1:0]   session_high,
    output logic [ohlcv_pkg::PRICE_W-1:0]   session_low,
    // configuration channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ohlcv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ohlcv_pkg::IVL_W-1:0]     cfg_data
);

    ohlcv_pkg::cfg_t  cfg;
    ohlcv_pkg::tick_t a_tick;
    logic             a_valid;
    logic             b_ready;

    // configuration registers; the timeout is held pre-scaled to ms
    ohlcv_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input stage: hold the tick, decode the type, form the turnover product
    ohlcv_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .tick_time_ms (tick_time_ms),
        .price        (price),
        .tick_volume  (tick_volume),
        .trade_type   (trade_type),
        .b_ready      (b_ready),
        .a_valid      (a_valid),
        .a_tick       (a_tick)
    );

    // bar stage: advance the bar and session state, register the result item
    ohlcv_bar u_bar (
        .clk             (clk),
        .rst_n           (rst_n),
        .a_valid         (a_valid),
        .a_tick          (a_tick),
        .cfg             (cfg),
        .b_ready         (b_ready),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .accepted        (accepted),
        .bar_closed      (bar_closed),
        .closed_start_ms (closed_start_ms),
        .closed_open     (closed_open),
        .closed_high     (closed_high),
        .closed_low      (closed_low),
        .closed_last     (closed_last),
        .closed_volume   (closed_volume),
        .closed_amount   (closed_amount),
        .closed_auction  (closed_auction),
        .session_high    (session_high),
        .session_low     (session_low)
    );

    // a closed bar only ever comes with an accepted tick
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!bar_closed || accepted))
        else $error("bar closed on a refused tick");

    // a set session low never exceeds the session high
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (session_low != '0)) |-> (session_low <= session_high))
        else $error("session low above session high");

    // a tick leaving the input stage shows up as a result the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid && b_ready) |=> out_valid)
        else $error("tick lost between input and bar stage");

    // the input stage only stalls while it holds a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (a_valid && out_valid && out_stall))
        else $error("input stalled without a held tick");

endmodule
